FILE: hdl/ahosc_pkg.sv
// shared types, codes and constants of the additive harmonic oscillator
package ahosc_pkg;

  // field widths of one beat
  localparam int FUNC_W   = 2;
  localparam int HARM_W   = 4;
  localparam int COEF_W   = 16;
  localparam int STEP_W   = 23;
  localparam int SAMPLE_W = 16;

  // function codes on the input side
  localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STEP = 2'd2;

  // classified commands passed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_COEF,
    OP_STEP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic [HARM_W-1:0]   idx;
    logic [STEP_W-1:0]   val;
  } cmd_t;

  // depth of the command queue between front and back
  localparam int QDEPTH = 2;

  // back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } back_state_t;

  // quarter-wave sine polynomial, Q16 constants
  localparam int          SINE_LAT = 5;
  localparam int          X_W      = 17;
  localparam int          MAG_W    = 15;
  localparam logic [16:0] SIN_A    = 17'd102944;
  localparam logic [15:0] SIN_B    = 16'd42047;
  localparam logic [12:0] SIN_C    = 13'd4640;

  // reset amplitude of harmonic k: round(32768 / k^2), k = 1..64
  localparam int COEF_TABLE_N = 64;
  localparam logic [COEF_W-1:0] COEF_INIT [COEF_TABLE_N] = '{
    16'd32768, 16'd8192, 16'd3641, 16'd2048, 16'd1311, 16'd910, 16'd669, 16'd512,
    16'd405,   16'd328,  16'd271,  16'd228,  16'd194,  16'd167, 16'd146, 16'd128,
    16'd113,   16'd101,  16'd91,   16'd82,   16'd74,   16'd68,  16'd62,  16'd57,
    16'd52,    16'd48,   16'd45,   16'd42,   16'd39,   16'd36,  16'd34,  16'd32,
    16'd30,    16'd28,   16'd27,   16'd25,   16'd24,   16'd23,  16'd22,  16'd20,
    16'd19,    16'd19,   16'd18,   16'd17,   16'd16,   16'd15,  16'd15,  16'd14,
    16'd14,    16'd13,   16'd13,   16'd12,   16'd12,   16'd11,  16'd11,  16'd10,
    16'd10,    16'd10,   16'd9,    16'd9,    16'd9,    16'd9,   16'd8,   16'd8
  };

endpackage

FILE: hdl/ahosc_front.sv
// input side: accepts beats and turns them into queue commands
module ahosc_front #(
  parameter int HARMONICS = 16
) (
  input  logic                          push,
  output logic                          full,
  input  logic [ahosc_pkg::FUNC_W-1:0]  func,
  input  logic [ahosc_pkg::HARM_W-1:0]  harmonic,
  input  logic [ahosc_pkg::COEF_W-1:0]  coefficient,
  input  logic [ahosc_pkg::STEP_W-1:0]  phase_step_in,
  input  logic                          q_full,
  output logic                          wr_en,
  output ahosc_pkg::cmd_t               wr_cmd
);
  import ahosc_pkg::*;

  logic keep;
  logic harm_ok;

  // coefficient writes past the last harmonic are dropped
  assign harm_ok = (32'(harmonic) < HARMONICS);

  // classify the beat
  always_comb begin
    keep       = 1'b0;
    wr_cmd.op  = OP_TICK;
    wr_cmd.idx = harmonic;
    wr_cmd.val = phase_step_in;
    unique case (func)
      FUNC_TICK: begin
        keep = 1'b1;
      end
      FUNC_COEF: begin
        wr_cmd.op  = OP_COEF;
        wr_cmd.val = STEP_W'(coefficient);
        keep       = harm_ok;
      end
      FUNC_STEP: begin
        wr_cmd.op = OP_STEP;
        keep      = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // accepted beats that do something go into the queue
  assign full  = q_full;
  assign wr_en = push && !q_full && keep;

endmodule

FILE: hdl/ahosc_cmd_queue.sv
// small command queue between the front and the back
module ahosc_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  ahosc_pkg::cmd_t  wr_cmd,
  output logic             full,
  input  logic             rd_en,
  output logic             empty,
  output ahosc_pkg::cmd_t  rd_cmd
);
  import ahosc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             slots [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command written into a full queue");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty)
    else $error("command taken from an empty queue");
`endif

endmodule

FILE: hdl/ahosc_sine.sv
// pipelined quarter-wave sine polynomial, magnitude out after five stages
module ahosc_sine (
  input  logic                         clk,
  input  logic [ahosc_pkg::X_W-1:0]    x_in,
  output logic [ahosc_pkg::MAG_W-1:0]  mag
);
  import ahosc_pkg::*;

  logic [33:0]    sq;
  logic [29:0]    ct;
  logic [32:0]    bv;
  logic [33:0]    av;
  logic [17:0]    rp1;
  logic [16:0]    q;

  logic [16:0]    x2_s1;
  logic [X_W-1:0] x_s1;
  logic [12:0]    t_s2;
  logic [16:0]    x2_s2;
  logic [X_W-1:0] x_s2;
  logic [15:0]    v_s3;
  logic [X_W-1:0] x_s3;
  logic [16:0]    r_s4;

  // x squared
  assign sq = 34'(x_in) * 34'(x_in);
  // c times x squared
  assign ct = 30'(SIN_C) * 30'(x2_s1);
  // (b - t) times x squared
  assign bv = 33'(SIN_B - 16'(t_s2)) * 33'(x2_s2);
  // (a - v) times x
  assign av = 34'(SIN_A - 17'(v_s3)) * 34'(x_s3);
  // round to q1.15
  assign rp1 = 18'(r_s4) + 18'd1;
  assign q   = rp1[17:1];

  always_ff @(posedge clk) begin
    x2_s1 <= sq[32:16];
    x_s1  <= x_in;
    t_s2  <= ct[28:16];
    x2_s2 <= x2_s1;
    x_s2  <= x_s1;
    v_s3  <= bv[31:16];
    x_s3  <= x_s2;
    r_s4  <= av[32:16];
    mag   <= (q > 17'd32767) ? {MAG_W{1'b1}} : q[MAG_W-1:0];
  end

endmodule

FILE: hdl/ahosc_back.sv
// back end: harmonic sequencer, coefficient store, accumulator, result register
module ahosc_back #(
  parameter int HARMONICS    = 16,
  parameter int SINE_ENTRIES = 1024,
  parameter int PHASE_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  ahosc_pkg::cmd_t                       q_cmd,
  output logic                                  q_pop,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [ahosc_pkg::SAMPLE_W-1:0] sample
);
  import ahosc_pkg::*;

  localparam int HIDX_W = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int INIT_W = $clog2(COEF_TABLE_N);
  localparam int LOG2N  = $clog2(SINE_ENTRIES);
  localparam int XS     = 16 - LOG2N;
  localparam int ACC_W  = 33 + $clog2(HARMONICS);
  localparam int PROD_W = COEF_W + MAG_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

  typedef struct packed {
    logic              vld;
    logic              lst;
    logic              neg;
    logic [COEF_W-1:0] coef;
  } tag_t;

  back_state_t state, state_next;

  logic                  start_tick;
  logic                  issue;
  logic                  coef_wr;
  logic                  step_wr;
  logic                  h_last;
  logic [HIDX_W-1:0]     h;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] p_cur;
  logic [STEP_W-1:0]     phase_step;

  logic [LOG2N-1:0]      j;
  logic [1:0]            quad;
  logic [LOG2N-1:0]      u;
  logic [X_W-1:0]        xe;
  logic [X_W-1:0]        x_issue;

  logic [COEF_W-1:0]     coef_mem [HARMONICS];
  logic                  coef_set [HARMONICS];
  logic [COEF_W-1:0]     cf_rd;
  logic                  cf_set_rd;
  logic [COEF_W-1:0]     cf_init_rd;
  logic [COEF_W-1:0]     coef_s1;

  logic                  s1_vld;
  logic                  s1_lst;
  logic                  s1_neg;
  logic [X_W-1:0]        s1_x;

  tag_t                  tag_d [SINE_LAT];
  tag_t                  tag_o;
  logic [MAG_W-1:0]      mag;

  logic                  m_vld;
  logic                  m_lst;
  logic                  m_neg;
  logic [PROD_W-1:0]     m_prod;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_sh;
  logic                    fin;
  logic                    out_valid;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] sample_r;

  assign h_last = (h == HIDX_W'(HARMONICS - 1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and command dispatch
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    start_tick = 1'b0;
    issue      = 1'b0;
    coef_wr    = 1'b0;
    step_wr    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            OP_TICK: begin
              if (!out_valid) begin
                q_pop      = 1'b1;
                start_tick = 1'b1;
                state_next = ST_RUN;
              end
            end
            OP_COEF: begin
              q_pop   = 1'b1;
              coef_wr = 1'b1;
            end
            OP_STEP: begin
              q_pop   = 1'b1;
              step_wr = 1'b1;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (h_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (fin) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // harmonic counter and running harmonic phase k * phase
  always_ff @(posedge clk) begin
    if (rst) begin
      h <= '0;
    end else if (start_tick) begin
      h <= '0;
    end else if (issue) begin
      h <= h + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_tick) begin
      p_cur <= phase;
    end else if (issue) begin
      p_cur <= p_cur + phase;
    end
  end

  // phase accumulator and step
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      phase_step <= '0;
    end else begin
      if (issue && h_last) begin
        phase <= phase + PHASE_BITS'(phase_step);
      end
      if (step_wr) begin
        phase_step <= q_cmd.val;
      end
    end
  end

  // table index, quadrant and quarter-turn fraction
  assign j       = p_cur[PHASE_BITS-1 -: LOG2N];
  assign quad    = j[LOG2N-1 -: 2];
  assign u       = {j[LOG2N-3:0], 2'b00};
  assign xe      = X_W'(u) << XS;
  assign x_issue = quad[0] ? ((X_W'(1) << 16) - xe) : xe;

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[HIDX_W'(q_cmd.idx)] <= q_cmd.val[COEF_W-1:0];
    end
    cf_rd      <= coef_mem[h];
    cf_init_rd <= COEF_INIT[INIT_W'(h)];
  end

  // written flags, an unwritten entry reads its reset amplitude
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HARMONICS; i++) begin
        coef_set[i] <= 1'b0;
      end
      cf_set_rd <= 1'b0;
    end else begin
      if (coef_wr) begin
        coef_set[HIDX_W'(q_cmd.idx)] <= 1'b1;
      end
      cf_set_rd <= coef_set[h];
    end
  end

  assign coef_s1 = cf_set_rd ? cf_rd : cf_init_rd;

  // first stage after issue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    s1_lst <= h_last;
    s1_neg <= quad[1];
    s1_x   <= x_issue;
  end

  // shared sine unit
  ahosc_sine u_sine (
    .clk  (clk),
    .x_in (s1_x),
    .mag  (mag)
  );

  // side data delayed to line up with the sine magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SINE_LAT; i++) begin
        tag_d[i] <= '0;
      end
    end else begin
      tag_d[0] <= '{vld: s1_vld, lst: s1_lst, neg: s1_neg, coef: coef_s1};
      for (int i = 1; i < SINE_LAT; i++) begin
        tag_d[i] <= tag_d[i-1];
      end
    end
  end

  assign tag_o = tag_d[SINE_LAT-1];

  // amplitude times sine magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= tag_o.vld;
    end
  end

  always_ff @(posedge clk) begin
    m_lst  <= tag_o.lst;
    m_neg  <= tag_o.neg;
    m_prod <= PROD_W'(tag_o.coef) * PROD_W'(mag);
  end

  // accumulate the signed products
  always_ff @(posedge clk) begin
    if (start_tick) begin
      acc <= '0;
    end else if (m_vld) begin
      acc <= m_neg ? acc - ACC_W'(m_prod) : acc + ACC_W'(m_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin <= 1'b0;
    end else begin
      fin <= m_vld && m_lst;
    end
  end

  // floor scale and saturate
  assign acc_sh = acc >>> 19;
  assign sat = (acc_sh > SAT_HI) ? 16'sh7FFF :
               (acc_sh < SAT_LO) ? 16'sh8000 : acc_sh[SAMPLE_W-1:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin) begin
      out_valid <= 1'b1;
    end else if (pop && out_valid) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      sample_r <= sat;
    end
  end

  assign empty  = !out_valid;
  assign sample = sample_r;

`ifndef SYNTHESIS
  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    fin |-> !out_valid)
    else $error("sample finished while the result register is occupied");

  a_pipe_empty_at_start: assert property (@(posedge clk) disable iff (rst)
    start_tick |-> (!s1_vld && !m_vld && !fin))
    else $error("tick started with harmonics still in flight");

  a_last_in_wait: assert property (@(posedge clk) disable iff (rst)
    (m_vld && m_lst) |-> (state == ST_WAIT))
    else $error("last harmonic product seen outside the wait state");
`endif

endmodule

FILE: hdl/additive_harmonic_oscillator_core.sv
// Additive harmonic oscillator. Each tick beat gives one signed 16-bit sample, the sum over
// harmonics k = 1..HARMONICS of amplitude[k] * sine(k * phase), divided by 2^19, floored and
// saturated; the phase then advances by the phase step modulo 2^PHASE_BITS. Coefficient and
// phase step beats give no result. A tick occupies the back end once it reaches the head of
// the two-entry command queue: one harmonic per cycle goes through a single shared sine
// polynomial and amplitude multiplier pipeline, then the pipeline drains into the accumulator.
// A tick waits at the head of the queue while the previous sample is still unread; input beats
// are taken as long as the queue has room. SINE_ENTRIES must be a power of two; amplitudes
// return to round(32768 / k^2) on reset.
module additive_harmonic_oscillator_core #(
  parameter int HARMONICS    = 16,
  parameter int SINE_ENTRIES = 1024,
  parameter int PHASE_BITS   = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic [ahosc_pkg::FUNC_W-1:0]          func,
  input  logic [ahosc_pkg::HARM_W-1:0]          harmonic,
  input  logic [ahosc_pkg::COEF_W-1:0]          coefficient,
  input  logic [ahosc_pkg::STEP_W-1:0]          phase_step_in,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [ahosc_pkg::SAMPLE_W-1:0] sample
);
  import ahosc_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_wr;
  logic q_pop;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  // beat classification
  ahosc_front #(
    .HARMONICS (HARMONICS)
  ) u_front (
    .push          (push),
    .full          (full),
    .func          (func),
    .harmonic      (harmonic),
    .coefficient   (coefficient),
    .phase_step_in (phase_step_in),
    .q_full        (q_full),
    .wr_en         (q_wr),
    .wr_cmd        (wr_cmd)
  );

  // decoupling queue
  ahosc_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .empty  (q_empty),
    .rd_cmd (rd_cmd)
  );

  // synthesis engine
  ahosc_back #(
    .HARMONICS    (HARMONICS),
    .SINE_ENTRIES (SINE_ENTRIES),
    .PHASE_BITS   (PHASE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (rd_cmd),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .sample  (sample)
  );

endmodule
